// ===== hdl/pmas_pkg.sv =====
package pmas_pkg;

  localparam int WINDOW      = 20;
  localparam int SAMPLE_BITS = 12;

  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = SAMPLE_BITS + CNT_W;
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int CODE_W  = 12;
  localparam int GAIN_W  = 16;
  localparam int OFS_W   = 22;
  localparam int PSI_W   = 8;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
  localparam int DIFF_W  = PROD_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd3481;
  localparam logic [OFS_W-1:0]  OFFSET_RESET = 22'd1425777;
  localparam logic [PSI_W-1:0]  MAX_RESET    = 8'd174;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } ring_stat_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== hdl/pmas_ring.sv =====
module pmas_ring
  import pmas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [SAMPLE_BITS-1:0] sample,
  output ring_stat_t             stat
);

  logic [SAMPLE_BITS-1:0] mem [WINDOW];
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0] new_sample;
  logic [PTR_W-1:0]       wpos;
  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       sum;
  logic                   drop;
  logic                   pend;

  // read-before-write: the old slot content comes out registered
  always_ff @(posedge clk) begin
    if (push) begin
      old_sample <= mem[wpos];
      mem[wpos]  <= sample;
      new_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos  <= '0;
      count <= '0;
      sum   <= '0;
      drop  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      pend <= push;
      if (push) begin
        if (wpos == PTR_W'(WINDOW - 1)) begin
          wpos <= '0;
        end else begin
          wpos <= wpos + 1'b1;
        end
        if (count == CNT_W'(WINDOW)) begin
          drop <= 1'b1;
        end else begin
          drop  <= 1'b0;
          count <= count + 1'b1;
        end
      end
      if (pend) begin
        sum <= sum - (drop ? SUM_W'(old_sample) : '0) + SUM_W'(new_sample);
      end
    end
  end

  assign stat.sum   = sum;
  assign stat.count = count;

endmodule

// ===== hdl/pmas_div.sv =====
module pmas_div
  import pmas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic [SUM_W-1:0] quotient,
  output logic             done
);

  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign rem_sh = {rem, dvd[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      if (!diff[CNT_W]) begin
        rem <= diff[CNT_W-1:0];
        dvd <= {dvd[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CNT_W-1:0];
        dvd <= {dvd[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

// ===== hdl/pressure_moving_average_scaler_core.sv =====
// Moving-average pressure scaler. Each accepted sample enters a 20-deep ring
// with a running sum; the rounded mean of the samples held so far goes out on
// average_code, and that mean scaled by gain_q16, less offset_q16, in whole PSI
// and clamped to 0..max_psi, goes out on pressure_psi with clamped marking a
// limit. A sample passes the ring update, divider start and wait, subtraction
// and clamp, mostly in the serial restoring divider that yields one quotient
// bit per cycle (17 bits); in_ready is low until its result is loaded.
// A result waits in the output register until taken, and the next sample then
// holds in_ready low at its last step until the register is free.
// Configuration writes are always accepted and only belong between items.
module pressure_moving_average_scaler_core
  import pmas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CODE_W-1:0]     adc_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_W-1:0]     average_code,
  output logic [PSI_W-1:0]      pressure_psi,
  output logic                  clamped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_SUB   = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;

  logic [2:0]             state;
  logic [GAIN_W-1:0]      gain_q16;
  logic [OFS_W-1:0]       offset_q16;
  logic [PSI_W-1:0]       max_psi;
  logic                   push;
  ring_stat_t             ring_stat;
  div_req_t               div_req;
  logic [SUM_W-1:0]       quotient;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] avg;
  logic [PROD_W-1:0]      prod;
  logic [DIFF_W-1:0]      diff;
  logic [SAMPLE_BITS-1:0] psi_full;
  logic                   out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q16   <= GAIN_RESET;
      offset_q16 <= OFFSET_RESET;
      max_psi    <= MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN:   gain_q16   <= cfg_data[GAIN_W-1:0];
        REG_OFFSET: offset_q16 <= cfg_data[OFS_W-1:0];
        REG_MAX:    max_psi    <= cfg_data[PSI_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign push     = in_valid && in_ready;

  pmas_ring u_ring (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .sample (SAMPLE_BITS'(adc_sample)),
    .stat   (ring_stat)
  );

  // half-up rounding: bias by half the count before dividing
  assign div_req.start    = (state == S_START);
  assign div_req.dividend = ring_stat.sum + SUM_W'(ring_stat.count >> 1);
  assign div_req.divisor  = ring_stat.count;

  pmas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .quotient (quotient),
    .done     (div_done)
  );

  assign psi_full = diff[PROD_W-1:FRAC_W];
  assign out_load = (state == S_CLAMP) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (state == S_WAIT && div_done) begin
      avg  <= SAMPLE_BITS'(quotient);
      prod <= PROD_W'(SAMPLE_BITS'(quotient)) * PROD_W'(gain_q16);
    end
    if (state == S_SUB) begin
      diff <= {1'b0, prod} - DIFF_W'(offset_q16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (push) begin
            state <= S_SUM;
          end
        end
        S_SUM:   state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            state <= S_SUB;
          end
        end
        S_SUB:   state <= S_CLAMP;
        S_CLAMP: begin
          if (out_load) begin
            average_code <= CODE_W'(avg);
            if (diff[DIFF_W-1]) begin
              pressure_psi <= '0;
              clamped      <= 1'b1;
            end else if (psi_full > SAMPLE_BITS'(max_psi)) begin
              pressure_psi <= max_psi;
              clamped      <= 1'b1;
            end else begin
              pressure_psi <= PSI_W'(psi_full);
              clamped      <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one item at a time: a transfer closes the input until the result is out
  assert property (@(posedge clk) disable iff (rst) push |=> !in_ready)
    else $error("input taken while an item is in progress");

  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_WAIT)
    else $error("divider finished outside its wait state");

  assert property (@(posedge clk) disable iff (rst)
    ring_stat.count <= CNT_W'(WINDOW))
    else $error("ring sample count beyond window");

endmodule
